// ===== rtl/core/alqr_pkg.sv =====
// ----------------------------------------------------------------------------
// alqr_pkg
// Types and constants for the quaternion attitude controller with integral
// action: payload structs, divider handshake, gains and the arctangent table.
// ----------------------------------------------------------------------------
package alqr_pkg;

    // input item
    typedef struct packed {
        logic signed [15:0] body_w;
        logic signed [15:0] body_x;
        logic signed [15:0] body_y;
        logic signed [15:0] body_z;
        logic signed [15:0] target_w;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] target_z;
        logic signed [15:0] rate_roll;
        logic signed [15:0] rate_pitch;
        logic signed [15:0] rate_yaw;
        logic               on_ground;
    } in_t;

    // result item
    typedef struct packed {
        logic signed [15:0] torque_roll;
        logic signed [15:0] torque_pitch;
        logic signed [15:0] torque_yaw;
    } out_t;

    // serial divider widths: dividend magnitude and divisor
    localparam int DIV_NUM_BITS = 54;
    localparam int DIV_DEN_BITS = 31;

    typedef struct packed {
        logic                    start;
        logic [DIV_NUM_BITS-1:0] dividend;
        logic [DIV_DEN_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic [DIV_NUM_BITS-1:0] quotient;
    } div_rsp_t;

    // register map
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    localparam logic [23:0] PERIOD_RST = 24'd41943;
    localparam logic [14:0] LIMIT_RST  = 15'd410;

    // angles in Q.20 radians
    localparam logic signed [24:0] ANG_PI      = 25'sd3294199;
    localparam logic signed [24:0] ANG_TWO_PI  = 25'sd6588397;
    localparam logic signed [23:0] ANG_HALF_PI = 24'sd1647099;

    localparam int CORDIC_STEPS = 21;

    localparam logic [19:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
        20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512, 20'd256,
        20'd128, 20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2, 20'd1
    };

    // gains, Q0.24, roll / pitch / yaw
    localparam logic [23:0] GAIN_I [3] = '{24'd503316, 24'd1342177, 24'd83886};
    localparam logic [23:0] GAIN_P [3] = '{24'd6291456, 24'd6291456, 24'd6710886};
    localparam logic [23:0] GAIN_D [3] = '{24'd1509949, 24'd2097152, 24'd1509949};

    // error quaternion product terms: body operand and sign per term
    localparam logic [1:0] B_SEL [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd2, 2'd3, 2'd0, 2'd1,
        2'd3, 2'd2, 2'd1, 2'd0
    };
    localparam logic B_NEG [16] = '{
        1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b0, 1'b1
    };

endpackage

// ===== rtl/core/alqr_div.sv =====
// ----------------------------------------------------------------------------
// alqr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alqr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  alqr_pkg::div_req_t req,
    output alqr_pkg::div_rsp_t rsp
);
    localparam int NB = alqr_pkg::DIV_NUM_BITS;
    localparam int DB = alqr_pkg::DIV_DEN_BITS;
    localparam int CB = $clog2(NB);

    logic [DB:0]   rem_reg;
    logic [NB-1:0] quo_reg;
    logic [DB-1:0] den_reg;
    logic [CB-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DB:0]   rem_sh;
    logic          fits;

    // shift in next dividend bit and trial subtract
    assign rem_sh = {rem_reg[DB-1:0], quo_reg[NB-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                den_reg  <= req.divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
                quo_reg <= {quo_reg[NB-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CB'(NB - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/core/attitude_lqr_integral_controller_top.sv =====
// ----------------------------------------------------------------------------
// attitude_lqr_integral_controller_top
// Quaternion attitude controller with clamped integrators and torque output.
// ----------------------------------------------------------------------------
// The block takes no new item from its input transfer until that item is
// finished; a zero error vector skips the angle and division steps. A single
// shared 33x33 multiplier serves the error quaternion, the sum of squares,
// the square root by trial squaring, the error products and the integrator
// and torque terms. A 21-step CORDIC finds the angle, and the three error
// components each wait on a bit-serial division, which takes most of the
// time of an item. The result waits in an output register, so the next item
// is taken while it is still pending. Registers: period at 0x0,
// integral_limit at 0x4.
module attitude_lqr_integral_controller_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  alqr_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output alqr_pkg::out_t m_payload,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_QUAT  = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_CINIT = 4'd4;
    localparam logic [3:0] ST_CORD  = 4'd5;
    localparam logic [3:0] ST_EANG  = 4'd6;
    localparam logic [3:0] ST_EMUL  = 4'd7;
    localparam logic [3:0] ST_EDIV  = 4'd8;
    localparam logic [3:0] ST_ICLR  = 4'd9;
    localparam logic [3:0] ST_INTG  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [1:0] OP_TERM = 2'd0;
    localparam logic [1:0] OP_INC  = 2'd1;
    localparam logic [1:0] OP_PROP = 2'd2;
    localparam logic [1:0] OP_RATE = 2'd3;

    logic [3:0]          state_reg;
    logic [4:0]          cnt_reg;
    logic                ph_reg;
    alqr_pkg::in_t       in_reg;
    logic [23:0]         period_reg;
    logic [14:0]         limit_reg;
    logic signed [33:0]  accq_reg [4];
    logic [60:0]         sq_reg;
    logic [30:0]         root_reg;
    logic signed [34:0]  cx_reg;
    logic signed [34:0]  cy_reg;
    logic signed [23:0]  cz_reg;
    logic signed [24:0]  ang_reg;
    logic signed [23:0]  err_reg [3];
    logic                neg_reg;
    logic signed [31:0]  t_reg;
    logic signed [49:0]  sum_reg;
    logic signed [31:0]  integ_reg [3];
    logic [15:0]         torq_reg [3];
    logic signed [65:0]  prod_reg;
    alqr_pkg::out_t      out_reg;
    logic                m_valid_reg;

    logic signed [15:0]  tq [4];
    logic signed [15:0]  bq [4];
    logic signed [15:0]  rt [3];
    logic signed [29:0]  v [3];
    logic signed [29:0]  vw;
    logic signed [32:0]  mul_a;
    logic signed [32:0]  mul_b;
    logic [30:0]         trial;
    logic [1:0]          axis;
    logic [1:0]          op;
    logic signed [65:0]  rnd16;
    logic signed [65:0]  rnd24;
    logic signed [33:0]  accv;
    logic signed [33:0]  lim;
    logic signed [33:0]  clamped;
    logic signed [49:0]  sum_p;
    logic signed [49:0]  sum_r;
    logic signed [17:0]  tq_full;
    logic [15:0]         tq_sat;
    logic signed [65:0]  mag;
    logic                cfg_wr;
    alqr_pkg::div_req_t  div_req;
    alqr_pkg::div_rsp_t  div_rsp;

    // payload views
    assign tq[0] = in_reg.target_w;
    assign tq[1] = in_reg.target_x;
    assign tq[2] = in_reg.target_y;
    assign tq[3] = in_reg.target_z;
    assign bq[0] = in_reg.body_w;
    assign bq[1] = in_reg.body_x;
    assign bq[2] = in_reg.body_y;
    assign bq[3] = in_reg.body_z;
    assign rt[0] = in_reg.rate_roll;
    assign rt[1] = in_reg.rate_pitch;
    assign rt[2] = in_reg.rate_yaw;

    // error quaternion floored to Q.24
    assign vw   = accq_reg[0][33:4];
    assign v[0] = accq_reg[1][33:4];
    assign v[1] = accq_reg[2][33:4];
    assign v[2] = accq_reg[3][33:4];

    assign trial = root_reg | (31'd1 << cnt_reg);
    assign axis  = cnt_reg[3:2];
    assign op    = cnt_reg[1:0];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_QUAT: begin
                mul_a = 33'(tq[cnt_reg[1:0]]);
                mul_b = 33'(bq[alqr_pkg::B_SEL[cnt_reg[3:0]]]);
            end
            ST_SQ: begin
                mul_a = 33'(v[cnt_reg[1:0]]);
                mul_b = 33'(v[cnt_reg[1:0]]);
            end
            ST_SQRT: begin
                mul_a = $signed({2'b00, trial});
                mul_b = $signed({2'b00, trial});
            end
            ST_EMUL: begin
                mul_a = 33'(v[cnt_reg[1:0]]);
                mul_b = 33'(ang_reg);
            end
            ST_INTG: begin
                unique case (op)
                    OP_TERM: begin
                        mul_a = 33'(err_reg[axis]);
                        mul_b = $signed({9'd0, period_reg});
                    end
                    OP_INC: begin
                        mul_a = 33'(t_reg);
                        mul_b = $signed({9'd0, alqr_pkg::GAIN_I[axis]});
                    end
                    OP_PROP: begin
                        mul_a = 33'(err_reg[axis]);
                        mul_b = $signed({9'd0, alqr_pkg::GAIN_P[axis]});
                    end
                    OP_RATE: begin
                        mul_a = 33'(rt[axis]);
                        mul_b = $signed({9'd0, alqr_pkg::GAIN_D[axis]});
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // integrator and torque arithmetic on the registered product
    always_comb begin
        rnd16   = prod_reg + 66'sd32768;
        rnd24   = prod_reg + 66'sd8388608;
        lim     = $signed({3'b000, limit_reg, 16'd0});
        accv    = 34'(integ_reg[axis]) + 34'($signed(rnd24[56:24]));
        if (accv > lim) begin
            clamped = lim;
        end else if (accv < -lim) begin
            clamped = -lim;
        end else begin
            clamped = accv;
        end
        sum_p   = -(50'(integ_reg[axis]) <<< 16) - $signed(prod_reg[49:0]);
        sum_r   = sum_reg - ($signed(prod_reg[49:0]) <<< 9) + 50'sd2147483648;
        tq_full = sum_r[49:32];
        if (tq_full > 18'sd32767) begin
            tq_sat = 16'h7fff;
        end else if (tq_full < -18'sd32768) begin
            tq_sat = 16'h8000;
        end else begin
            tq_sat = tq_full[15:0];
        end
        mag = prod_reg[65] ? -prod_reg : prod_reg;
    end

    // divider request
    assign div_req.start    = (state_reg == ST_EMUL) && ph_reg;
    assign div_req.dividend = mag[alqr_pkg::DIV_NUM_BITS-1:0];
    assign div_req.divisor  = root_reg;

    alqr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // shared multiplier, one product per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ph_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                integ_reg[k] <= '0;
            end
        end else begin
            // result transfer empties the output register unless a new one loads
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_payload;
                        for (int k = 0; k < 4; k++) begin
                            accq_reg[k] <= '0;
                        end
                        cnt_reg   <= '0;
                        ph_reg    <= 1'b0;
                        state_reg <= ST_QUAT;
                    end
                end
                ST_QUAT: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        if (alqr_pkg::B_NEG[cnt_reg[3:0]]) begin
                            accq_reg[cnt_reg[3:2]] <= accq_reg[cnt_reg[3:2]]
                                - $signed(prod_reg[33:0]);
                        end else begin
                            accq_reg[cnt_reg[3:2]] <= accq_reg[cnt_reg[3:2]]
                                + $signed(prod_reg[33:0]);
                        end
                        if (cnt_reg == 5'd15) begin
                            cnt_reg   <= '0;
                            sq_reg    <= '0;
                            state_reg <= ST_SQ;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_SQ: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        sq_reg <= sq_reg + prod_reg[60:0];
                        if (cnt_reg == 5'd2) begin
                            cnt_reg   <= 5'd30;
                            root_reg  <= '0;
                            state_reg <= ST_SQRT;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                // root bits from the top down, each kept when its square fits
                ST_SQRT: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        if (prod_reg[61:0] <= {1'b0, sq_reg}) begin
                            root_reg <= trial;
                        end
                        if (cnt_reg == 5'd0) begin
                            state_reg <= ST_CINIT;
                        end else begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                end
                // zero norm gives a zero error, else pre-rotate for w below zero
                ST_CINIT: begin
                    cnt_reg <= '0;
                    if (root_reg == '0) begin
                        for (int k = 0; k < 3; k++) begin
                            err_reg[k] <= '0;
                        end
                        state_reg <= ST_ICLR;
                    end else begin
                        if (vw < 0) begin
                            cx_reg <= $signed({4'd0, root_reg});
                            cy_reg <= -35'(vw);
                            cz_reg <= alqr_pkg::ANG_HALF_PI;
                        end else begin
                            cx_reg <= 35'(vw);
                            cy_reg <= $signed({4'd0, root_reg});
                            cz_reg <= '0;
                        end
                        state_reg <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (cy_reg > 0) begin
                        cx_reg <= cx_reg + (cy_reg >>> cnt_reg);
                        cy_reg <= cy_reg - (cx_reg >>> cnt_reg);
                        cz_reg <= cz_reg + $signed({4'd0, alqr_pkg::ATAN_TAB[cnt_reg]});
                    end else begin
                        cx_reg <= cx_reg - (cy_reg >>> cnt_reg);
                        cy_reg <= cy_reg + (cx_reg >>> cnt_reg);
                        cz_reg <= cz_reg - $signed({4'd0, alqr_pkg::ATAN_TAB[cnt_reg]});
                    end
                    if (cnt_reg == 5'(alqr_pkg::CORDIC_STEPS - 1)) begin
                        state_reg <= ST_EANG;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                // double the half angle and wrap into (-pi, pi]
                ST_EANG: begin
                    if ($signed({cz_reg, 1'b0}) > alqr_pkg::ANG_PI) begin
                        ang_reg <= $signed({cz_reg, 1'b0}) - alqr_pkg::ANG_TWO_PI;
                    end else begin
                        ang_reg <= $signed({cz_reg, 1'b0});
                    end
                    cnt_reg   <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= ST_EMUL;
                end
                ST_EMUL: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        neg_reg   <= prod_reg[65];
                        state_reg <= ST_EDIV;
                    end
                end
                // quotient truncated toward zero
                ST_EDIV: begin
                    if (div_rsp.done) begin
                        err_reg[cnt_reg[1:0]] <= neg_reg
                            ? -$signed(div_rsp.quotient[23:0])
                            : $signed(div_rsp.quotient[23:0]);
                        if (cnt_reg == 5'd2) begin
                            state_reg <= ST_ICLR;
                        end else begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= ST_EMUL;
                        end
                    end
                end
                ST_ICLR: begin
                    if (in_reg.on_ground) begin
                        for (int k = 0; k < 3; k++) begin
                            integ_reg[k] <= '0;
                        end
                    end
                    cnt_reg   <= '0;
                    ph_reg    <= 1'b0;
                    state_reg <= ST_INTG;
                end
                // per axis: error term, integrator, proportional, rate
                ST_INTG: begin
                    ph_reg <= !ph_reg;
                    if (ph_reg) begin
                        unique case (op)
                            OP_TERM: t_reg <= rnd16[47:16];
                            OP_INC:  integ_reg[axis] <= clamped[31:0];
                            OP_PROP: sum_reg <= sum_p;
                            OP_RATE: torq_reg[axis] <= tq_sat;
                            default: ;
                        endcase
                        if (cnt_reg == 5'd11) begin
                            state_reg <= ST_OUT;
                        end else begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.torque_roll  <= torq_reg[0];
                        out_reg.torque_pitch <= torq_reg[1];
                        out_reg.torque_yaw   <= torq_reg[2];
                        m_valid_reg          <= 1'b1;
                        state_reg            <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= alqr_pkg::PERIOD_RST;
            limit_reg  <= alqr_pkg::LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                alqr_pkg::REG_PERIOD: period_reg <= pwdata[23:0];
                alqr_pkg::REG_LIMIT:  limit_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            alqr_pkg::REG_PERIOD: prdata = {8'd0, period_reg};
            alqr_pkg::REG_LIMIT:  prdata = {17'd0, limit_reg};
            default:              prdata = '0;
        endcase
    end

    assign pready    = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== rtl/core/alqr_checker.sv =====
// ----------------------------------------------------------------------------
// alqr_checker
// Port-level checks on the attitude controller, bound to the top level.
// ----------------------------------------------------------------------------
module alqr_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input alqr_pkg::out_t m_payload,
    input logic           pready
);
    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    // an input transfer starts a multi-cycle computation
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after input transfer");

    // a new result only appears at the end of a computation
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without computation");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind attitude_lqr_integral_controller_top alqr_checker u_alqr_checker (.*);

// ===== tb/sv/alqr_checker.sv =====
// ----------------------------------------------------------------------------
// alqr_scoreboard
// Watches the input, result and register ports of the attitude controller,
// predicts each torque triple from its own copy of the integrators and
// registers, and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module alqr_scoreboard (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  alqr_pkg::in_t  s_payload,
    input  logic           m_valid,
    input  logic           m_ready,
    input  alqr_pkg::out_t m_payload,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output int             fails,
    output int             pending
);
    logic [23:0]        period_q;
    logic [14:0]        limit_q;
    logic signed [31:0] integ_q [3];
    alqr_pkg::out_t     torque_q [$];

    // floored integer square root
    function automatic longint unsigned int_sqrt(longint unsigned a);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= r + b) begin
                a = a - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle of (xs, ys) for ys >= 0 in Q.20 radians
    function automatic longint angle_of(longint ys, longint xs);
        longint x, y, z, nx, ny;
        if (xs < 0) begin
            x = ys;
            y = -xs;
            z = longint'(alqr_pkg::ANG_HALF_PI);
        end else begin
            x = xs;
            y = ys;
            z = 0;
        end
        for (int i = 0; i < alqr_pkg::CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(alqr_pkg::ATAN_TAB[i]);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(alqr_pkg::ATAN_TAB[i]);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // one control tick: updates the integrators, returns the torque triple
    function automatic alqr_pkg::out_t control_tick(alqr_pkg::in_t d);
        longint bw, bx, by, bz, tw, tx, ty, tz;
        longint vw, len, ang, lim, t, acc, sum, tq;
        longint v [3];
        longint err [3];
        longint rate [3];
        logic signed [15:0] tqv [3];
        alqr_pkg::out_t r;
        bw = d.body_w;   bx = d.body_x;   by = d.body_y;   bz = d.body_z;
        tw = d.target_w; tx = d.target_x; ty = d.target_y; tz = d.target_z;
        rate[0] = d.rate_roll;
        rate[1] = d.rate_pitch;
        rate[2] = d.rate_yaw;
        // error quaternion conj(target) * body, floored to Q.24
        vw   = (tw * bw + tx * bx + ty * by + tz * bz) >>> 4;
        v[0] = (tw * bx - tx * bw - ty * bz + tz * by) >>> 4;
        v[1] = (tw * by + tx * bz - ty * bw - tz * bx) >>> 4;
        v[2] = (tw * bz - tx * by + ty * bx - tz * bw) >>> 4;
        len = longint'(int_sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]));
        for (int k = 0; k < 3; k++) err[k] = 0;
        if (len != 0) begin
            ang = 2 * angle_of(len, vw);
            if (ang > longint'(alqr_pkg::ANG_PI)) ang = ang - longint'(alqr_pkg::ANG_TWO_PI);
            for (int k = 0; k < 3; k++) err[k] = (v[k] * ang) / len;
        end
        if (d.on_ground) begin
            for (int k = 0; k < 3; k++) integ_q[k] = '0;
        end
        lim = longint'(limit_q) * 65536;
        for (int k = 0; k < 3; k++) begin
            t   = round_shift(err[k] * longint'(period_q), 16);
            acc = longint'(integ_q[k])
                + round_shift(t * longint'(alqr_pkg::GAIN_I[k]), 24);
            if (acc > lim) acc = lim;
            if (acc < -lim) acc = -lim;
            integ_q[k] = acc[31:0];
            sum = -acc * 65536 - err[k] * longint'(alqr_pkg::GAIN_P[k])
                - rate[k] * longint'(alqr_pkg::GAIN_D[k]) * 512;
            tq = round_shift(sum, 32);
            if (tq > 32767) tq = 32767;
            if (tq < -32768) tq = -32768;
            tqv[k] = tq[15:0];
        end
        r.torque_roll  = tqv[0];
        r.torque_pitch = tqv[1];
        r.torque_yaw   = tqv[2];
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("error at %0t: %s got %0d want %0d", $time, what, got, want);
        fails = fails + 1;
    endtask

    // register writes, input predictions, result compares
    always @(posedge aclk) begin
        alqr_pkg::out_t want;
        if (!aresetn) begin
            period_q = alqr_pkg::PERIOD_RST;
            limit_q  = alqr_pkg::LIMIT_RST;
            for (int k = 0; k < 3; k++) integ_q[k] = '0;
            torque_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == alqr_pkg::REG_PERIOD) period_q = pwdata[23:0];
                else if (paddr[2] == alqr_pkg::REG_LIMIT) limit_q = pwdata[14:0];
            end
            if (s_valid && s_ready) torque_q.push_back(control_tick(s_payload));
            if (m_valid && m_ready) begin
                if (torque_q.size() == 0) begin
                    report("unexpected result transfer", 0, 0);
                end else begin
                    want = torque_q.pop_front();
                    if (m_payload.torque_roll !== want.torque_roll)
                        report("torque_roll", m_payload.torque_roll, want.torque_roll);
                    if (m_payload.torque_pitch !== want.torque_pitch)
                        report("torque_pitch", m_payload.torque_pitch, want.torque_pitch);
                    if (m_payload.torque_yaw !== want.torque_yaw)
                        report("torque_yaw", m_payload.torque_yaw, want.torque_yaw);
                end
            end
        end
        pending <= torque_q.size();
    end

endmodule

// ===== tb/sv/tb_attitude_lqr_integral_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_attitude_lqr_integral_controller_top
// Drives directed and random attitude ticks through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_attitude_lqr_integral_controller_top;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    alqr_pkg::in_t  s_payload = '0;
    logic           m_valid;
    logic           m_ready = 1'b1;
    alqr_pkg::out_t m_payload;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [2:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;
    int             fails;
    int             pending;
    bit             calm = 1'b0;
    int             stall_left = 0;

    always #5 aclk = ~aclk;

    attitude_lqr_integral_controller_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    alqr_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
    );

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (calm || !aresetn) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        #40000000;
        $display("attitude_lqr_integral_controller_top: mismatch");
        $finish;
    end

    task automatic send_tick(alqr_pkg::in_t d);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic reg_write(logic idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic alqr_pkg::in_t tick_of(int bw, int bx, int by, int bz, int tw,
                                              int tx, int ty, int tz, int rr, int rp,
                                              int ry, bit g);
        alqr_pkg::in_t d;
        d.body_w = 16'(bw);     d.body_x = 16'(bx);
        d.body_y = 16'(by);     d.body_z = 16'(bz);
        d.target_w = 16'(tw);   d.target_x = 16'(tx);
        d.target_y = 16'(ty);   d.target_z = 16'(tz);
        d.rate_roll = 16'(rr);  d.rate_pitch = 16'(rp); d.rate_yaw = 16'(ry);
        d.on_ground = g;
        return d;
    endfunction

    function automatic int clip_q(int v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // random quaternion, mostly scaled to unit length
    task automatic rand_quat(output int q [4]);
        real r [4];
        real n;
        bit raw;
        raw = ($urandom_range(0, 7) == 0);
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            q[i] = $urandom_range(0, 32768) - 16384;
            r[i] = q[i];
            n = n + r[i] * r[i];
        end
        if (!raw) begin
            if (n < 1.0) begin
                q[0] = 16384; q[1] = 0; q[2] = 0; q[3] = 0;
            end else begin
                for (int i = 0; i < 4; i++) q[i] = clip_q($rtoi(r[i] * 16384.0 / $sqrt(n)));
            end
        end
    endtask

    function automatic int rand_rate();
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 8192) - 4096;
    endfunction

    task automatic random_ticks(int n);
        int b [4];
        int t [4];
        int span;
        for (int i = 0; i < n; i++) begin
            rand_quat(b);
            case ($urandom_range(0, 3))
                0, 1: begin
                    // target close to body: small error angles
                    span = ($urandom_range(0, 1) == 0) ? 64 : 1500;
                    for (int j = 0; j < 4; j++)
                        t[j] = clip_q(b[j] + $urandom_range(0, 2 * span) - span);
                end
                default: rand_quat(t);
            endcase
            // flipped sign covers the negative scalar path
            if ($urandom_range(0, 3) == 0)
                for (int j = 0; j < 4; j++) t[j] = -t[j];
            send_tick(tick_of(b[0], b[1], b[2], b[3], t[0], t[1], t[2], t[3],
                              rand_rate(), rand_rate(), rand_rate(),
                              $urandom_range(0, 9) == 0));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed ticks at reset settings
        send_tick(tick_of(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 32767, -32768, 32767, 0));
        send_tick(tick_of(0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 16384, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(-16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                          32767, 32767, 32767, 0));
        send_tick(tick_of(-16384, -16384, -16384, -16384, 16384, -16384, 16384, -16384,
                          -32768, -32768, -32768, 0));
        send_tick(tick_of(11585, 11585, 0, 0, 16384, 0, 0, 0, 1000, -1000, 500, 0));
        send_tick(tick_of(-11585, 11585, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(-16000, 3000, -2000, 1000, 16384, 0, 0, 0, 0, 0, 0, 0));
        send_tick(tick_of(16380, 100, -50, 30, 16384, 0, 0, 0, -20, 20, 0, 0));
        send_tick(tick_of(8192, 8192, 8192, 8192, 0, 0, 0, 16384, 0, 0, 0, 1));
        send_tick(tick_of(16384, 0, 0, 0, 0, -16384, 0, 0, 32767, 32767, 32767, 0));
        send_tick(tick_of(1, -1, 1, -1, -1, 1, -1, 1, 0, 0, 0, 1));
        drain();

        // extreme and random register settings
        reg_write(alqr_pkg::REG_PERIOD, 32'd16777215);
        reg_write(alqr_pkg::REG_LIMIT, 32'd32767);
        random_ticks(200);
        drain();
        reg_write(alqr_pkg::REG_PERIOD, 32'd1);
        reg_write(alqr_pkg::REG_LIMIT, 32'd0);
        random_ticks(150);
        drain();
        reg_write(alqr_pkg::REG_PERIOD, 32'd0);
        reg_write(alqr_pkg::REG_LIMIT, 32'd410);
        random_ticks(100);
        drain();
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(alqr_pkg::REG_PERIOD, $urandom_range(1, 16777215));
            reg_write(alqr_pkg::REG_LIMIT, $urandom_range(0, 32767));
            random_ticks(200);
            drain();
        end
        reg_write(alqr_pkg::REG_PERIOD, 32'd41943);
        reg_write(alqr_pkg::REG_LIMIT, 32'd4096);
        random_ticks(150);
        calm = 1'b1;
        random_ticks(200);
        drain();
        repeat (400) @(posedge aclk);

        if (fails == 0 && pending == 0) begin
            $display("attitude_lqr_integral_controller_top: match");
        end else begin
            $display("attitude_lqr_integral_controller_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== attitude_lqr_integral_controller_top.f =====
rtl/core/alqr_pkg.sv
rtl/core/alqr_div.sv
rtl/core/attitude_lqr_integral_controller_top.sv
rtl/core/alqr_checker.sv
tb/sv/alqr_checker.sv
tb/sv/tb_attitude_lqr_integral_controller_top.sv
